### rtl/core/cooperative_task_scheduler_macros.svh
// assertion macros for the cooperative task scheduler
// expects clk_i and rst_ni in the scope of use
`ifndef COOPERATIVE_TASK_SCHEDULER_MACROS_SVH
`define COOPERATIVE_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cts assertion failed");
`define CTS_ASSERT_NEVER(lbl, cond) \
  `CTS_ASSERT(lbl, !(cond))
`else
`define CTS_ASSERT(lbl, prop)
`define CTS_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/core/cts_pkg.sv
// shared types and constants of the cooperative task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

  localparam int Slots      = 8;
  localparam int MaxResults = 8;
  localparam int SlotW      = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int NfW        = $clog2(Slots + 1);
  localparam int CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_DELETE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_TICK_DONE = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_RUN       = 3'd3,
    ST_NONE      = 3'd4,
    ST_DELETED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  slot_id;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] task_slot;
    logic       last;
  } out_t;

  typedef struct packed {
    logic step;
    logic tick;
    logic disp;
    logic kill;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/cts_cell.sv
// one task slot of the scheduler chain: slot state plus walk token
// depends on cts_pkg
`timescale 1ns / 1ps
`default_nettype none
module cts_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cts_pkg::cell_ctrl_t ctrl_i,
  input  logic              tok_i,
  output logic              tok_o,
  input  logic              add_i,
  input  logic              del_i,
  input  logic [31:0]       add_delay_i,
  input  logic [31:0]       add_period_i,
  output logic              hit_o
);
  import cts_pkg::*;

  logic        valid_q, valid_d;
  logic        tok_q, tok_d;
  logic [31:0] delay_q, delay_d;
  logic [31:0] period_q, period_d;
  logic [7:0]  pend_q, pend_d;
  logic        busy;

  assign busy  = ctrl_i.step & tok_q & valid_q;
  assign hit_o = ctrl_i.disp & tok_q & valid_q & (pend_q != 8'd0);
  assign tok_o = tok_q;

  always_comb begin
    valid_d  = valid_q;
    delay_d  = delay_q;
    period_d = period_q;
    pend_d   = pend_q;
    tok_d    = tok_q;
    if (ctrl_i.kill) begin
      tok_d = 1'b0;
    end else if (ctrl_i.step) begin
      tok_d = tok_i;
    end
    if (add_i) begin
      valid_d  = 1'b1;
      delay_d  = add_delay_i;
      period_d = add_period_i;
      pend_d   = 8'd0;
    end else if (del_i) begin
      valid_d = 1'b0;
    end else if (busy && ctrl_i.tick) begin
      if (delay_q != 32'd0) begin
        delay_d = delay_q - 32'd1;
      end else begin
        delay_d = period_q;
        if (pend_q != 8'hFF) begin
          pend_d = pend_q + 8'd1;
        end
      end
    end else if (busy && hit_o) begin
      pend_d = pend_q - 8'd1;
      if (period_q == 32'd0) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q  <= delay_d;
    period_q <= period_d;
    pend_q   <= pend_d;
  end

endmodule
`default_nettype wire

### rtl/core/cooperative_task_scheduler.sv
// Cooperative time-triggered task scheduler, top level.
// Input channel in_valid_i/in_ready_o/in_data_i carries one command per
// transaction: add task, tick, dispatch or delete task. Output channel
// out_valid_o/out_ready_i/out_data_o carries result transactions; the last
// result of a command has last set.
// The slots form a chain of cells; a walk token moves one cell per cycle
// unless a stalled receiver holds a dispatch walk. Tick: walks all Slots
// cells. Dispatch: walks the cells, one run order per slot with pending
// runs (at most MaxResults), each held back until the next run order or
// the end of the walk shows whether it is the last. One command is in work
// at a time; the next is accepted the cycle after the final result is
// registered.
// A stalled receiver holds the output register; a dispatch walk then waits
// at the cell that has a run order to hand over.
// Reset clears all slot valid bits, the next free slot and the walk.
// depends on cts_pkg, cts_cell and cooperative_task_scheduler_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "cooperative_task_scheduler_macros.svh"
module cooperative_task_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cts_pkg::out_t out_data_o
);
  import cts_pkg::*;

  fsm_e             state_q, state_d;
  in_t              req_q;
  logic [NfW-1:0]   next_free_q, next_free_d;
  logic [SlotW-1:0] walk_idx_q, walk_idx_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             hold_valid_q, hold_valid_d;
  logic [SlotW-1:0] hold_slot_q, hold_slot_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             in_fire, start, out_can_load, any_hit;
  logic             add_en, del_en, is_walk_act;
  cell_ctrl_t       ctrl;
  logic [Slots:0]   tok;
  logic [Slots-1:0] hit;

  assign in_ready_o   = (state_q == FSM_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign is_walk_act  = (in_data_i.action == ACT_TICK) || (in_data_i.action == ACT_DISPATCH);
  assign start        = in_fire & is_walk_act;
  assign out_can_load = !out_valid_q || out_ready_i;
  assign any_hit      = |hit;
  assign tok[0]       = start;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ctrl.tick = (state_q == FSM_WALK) && (req_q.action == ACT_TICK);
    ctrl.disp = (state_q == FSM_WALK) && (req_q.action == ACT_DISPATCH);
    ctrl.step = !(ctrl.disp && any_hit && hold_valid_q && !out_can_load);
    ctrl.kill = ctrl.disp && any_hit && ctrl.step && (n_q == CntW'(MaxResults - 1));
  end

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    cts_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tok_i        (tok[i]),
      .tok_o        (tok[i+1]),
      .add_i        (add_en && (next_free_q == NfW'(i))),
      .del_i        (del_en && (req_q.slot_id == 8'(i))),
      .add_delay_i  (req_q.delay),
      .add_period_i (req_q.period),
      .hit_o        (hit[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    next_free_d  = next_free_q;
    walk_idx_d   = walk_idx_q;
    n_d          = n_q;
    hold_valid_d = hold_valid_q;
    hold_slot_d  = hold_slot_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    add_en       = 1'b0;
    del_en       = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          walk_idx_d   = '0;
          n_d          = '0;
          hold_valid_d = 1'b0;
          state_d      = is_walk_act ? FSM_WALK : FSM_DONE;
        end
      end
      FSM_WALK: begin
        if (ctrl.step) begin
          walk_idx_d = walk_idx_q + SlotW'(1);
          if (ctrl.disp && any_hit) begin
            n_d          = n_q + CntW'(1);
            hold_valid_d = 1'b1;
            hold_slot_d  = walk_idx_q;
            if (hold_valid_q) begin
              out_valid_d      = 1'b1;
              out_d.status     = ST_RUN;
              out_d.task_slot  = 3'(hold_slot_q);
              out_d.last       = 1'b0;
            end
          end
          if (ctrl.kill || tok[Slots]) begin
            state_d = FSM_DONE;
          end
        end
      end
      FSM_DONE: begin
        if (out_can_load) begin
          out_valid_d     = 1'b1;
          out_d.last      = 1'b1;
          out_d.task_slot = 3'd0;
          state_d         = FSM_IDLE;
          unique case (req_q.action)
            ACT_ADD: begin
              if (next_free_q != NfW'(Slots)) begin
                add_en          = 1'b1;
                next_free_d     = next_free_q + NfW'(1);
                out_d.status    = ST_ADDED;
                out_d.task_slot = 3'(next_free_q);
              end else begin
                out_d.status = ST_FULL;
              end
            end
            ACT_TICK: out_d.status = ST_TICK_DONE;
            ACT_DISPATCH: begin
              if (hold_valid_q) begin
                out_d.status    = ST_RUN;
                out_d.task_slot = 3'(hold_slot_q);
                hold_valid_d    = 1'b0;
              end else begin
                out_d.status = ST_NONE;
              end
            end
            ACT_DELETE: begin
              del_en       = 1'b1;
              out_d.status = ST_DELETED;
            end
            default: out_d.status = ST_DELETED;
          endcase
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      next_free_q  <= '0;
      walk_idx_q   <= '0;
      n_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_free_q  <= next_free_d;
      walk_idx_q   <= walk_idx_d;
      n_q          <= n_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_slot_q <= hold_slot_d;
    out_q       <= out_d;
    if (in_fire) begin
      req_q <= in_data_i;
    end
  end

  `CTS_ASSERT(a_tok_onehot0, $onehot0(tok[Slots:1]))
  `CTS_ASSERT(a_hold_in_walk, hold_valid_q |-> (state_q == FSM_WALK || state_q == FSM_DONE))
  `CTS_ASSERT_NEVER(a_count_bound, n_q > CntW'(MaxResults))
  `CTS_ASSERT(a_kill_ends_walk, ctrl.kill |=> (state_q == FSM_DONE))

endmodule
`default_nettype wire
